// ===== rtl/ipp_pkg.sv =====
// Shared types and constants for the indexed pixel packer.
package ipp_pkg;

  localparam int unsigned PIX_W    = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COL_W    = 15;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 1'd1;

  localparam logic [COL_W-1:0] ROW_WIDTH_RST = 15'd1;

  // Bits per pixel.
  typedef enum logic [1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_2BPP = 2'd1,
    DEPTH_4BPP = 2'd2,
    DEPTH_8BPP = 2'd3
  } depth_t;

  // Outcome of packing one pixel into the byte under construction.
  typedef struct packed {
    logic              emit;
    logic              row_end;
    logic [BYTE_W-1:0] out_byte;
    logic [BYTE_W-1:0] partial_nxt;
    logic [COL_W-1:0]  col_nxt;
  } pack_res_t;

endpackage

// ===== rtl/ipp_pack.sv =====
// Shift-or packing of one pixel into the current byte and row bookkeeping.
module ipp_pack (
  input  ipp_pkg::depth_t                  depth,
  input  logic [ipp_pkg::COL_W-1:0]        row_width,
  input  logic [ipp_pkg::COL_W-1:0]        col,
  input  logic [ipp_pkg::BYTE_W-1:0]       partial,
  input  logic [ipp_pkg::PIX_W-1:0]        pix,
  output ipp_pkg::pack_res_t               res
);
  import ipp_pkg::*;

  logic [2:0]        shift;
  logic [BYTE_W-1:0] pix8;
  logic              full;
  logic [BYTE_W-1:0] merged;
  logic [COL_W:0]    col_inc;
  logic              last;

  always_comb begin
    unique case (depth)
      DEPTH_1BPP: begin
        shift = 3'd7 - col[2:0];
        pix8  = {7'b0, pix[0]};
        full  = (col[2:0] == 3'd7);
      end
      DEPTH_2BPP: begin
        shift = 3'd6 - {col[1:0], 1'b0};
        pix8  = {6'b0, pix[1:0]};
        full  = (col[1:0] == 2'd3);
      end
      DEPTH_4BPP: begin
        shift = col[0] ? 3'd0 : 3'd4;
        pix8  = {4'b0, pix[3:0]};
        full  = col[0];
      end
      DEPTH_8BPP: begin
        shift = 3'd0;
        pix8  = pix[BYTE_W-1:0];
        full  = 1'b1;
      end
    endcase
  end

  assign merged  = partial | (pix8 << shift);
  // A zero or lowered row width still ends the row on this pixel.
  assign col_inc = {1'b0, col} + {{COL_W{1'b0}}, 1'b1};
  assign last    = (col_inc >= {1'b0, row_width});

  always_comb begin
    res.emit        = full | last;
    res.row_end     = last;
    res.out_byte    = merged;
    res.partial_nxt = (full | last) ? '0 : merged;
    res.col_nxt     = last ? '0 : col_inc[COL_W-1:0];
  end

endmodule

// ===== rtl/ipp_out_reg.sv =====
// Result register holding one packed byte until the consumer takes it.
module ipp_out_reg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [ipp_pkg::BYTE_W-1:0]  load_byte,
  input  logic                        load_row_end,
  input  logic                        out_ready,
  output logic                        free,
  output logic                        out_valid,
  output logic [ipp_pkg::BYTE_W-1:0]  out_packed_byte,
  output logic                        out_row_end
);
  import ipp_pkg::*;

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              row_end_r;

  assign free      = ~valid_r | out_ready;
  assign valid_nxt = load | (valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r    <= load_byte;
      row_end_r <= load_row_end;
    end
  end

  assign out_valid       = valid_r;
  assign out_packed_byte = byte_r;
  assign out_row_end     = row_end_r;

endmodule

// ===== rtl/indexed_pixel_packer_core.sv =====
// Indexed pixel packer: packs palette indices MSB-first into bytes, one pixel a cycle unless stalled.
//
// Each accepted word carries one palette index in raster order. It is masked to
// the configured depth (1, 2, 4 or 8 bits) and or-ed into the byte under
// construction, first pixel of a byte in its high bits. A byte goes out when its
// last slot fills or when the pixel ends its row; a row-end byte carries unused
// low slots as zero and has out_row_end set. The block takes one word every
// cycle unless stalled: a word is held in the input register, is packed by a
// single shift-or between that register and the result register, and shows on
// the output from the result register. A stalled result register stalls packing
// only when the pixel in hand would produce a byte; pixels that only fill a slot
// keep flowing. Write depth_code (index 0) and row_width (index 1) only while
// the block is idle; a write leaves the column position and partial byte as they
// are. After reset depth is 8 bits and the row width is one pixel.
module indexed_pixel_packer_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ipp_pkg::PIX_W-1:0]      in_pixel_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ipp_pkg::BYTE_W-1:0]     out_packed_byte,
  output logic                           out_row_end,
  input  logic                           cfg_we,
  input  logic [ipp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipp_pkg::CFG_W-1:0]      cfg_wdata
);
  import ipp_pkg::*;

  // Configuration registers.
  depth_t           depth_r;
  logic [COL_W-1:0] row_width_r;

  // Input register.
  logic             in_vld_r;
  logic [PIX_W-1:0] pix_r;

  // Packing state.
  logic [COL_W-1:0]  col_r;
  logic [BYTE_W-1:0] partial_r;

  pack_res_t res;
  logic      out_free;
  logic      advance;
  logic      in_fire;
  logic      in_vld_nxt;

  // Hold configuration; ignore indexes outside the register list.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= DEPTH_8BPP;
      row_width_r <= ROW_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH_CODE: depth_r     <= depth_t'(cfg_wdata[1:0]);
        CFG_ROW_WIDTH:  row_width_r <= cfg_wdata[COL_W-1:0];
        default:        ;
      endcase
    end
  end

  // Advance the held pixel unless it makes a byte and the result register is stalled.
  assign advance    = in_vld_r & (~res.emit | out_free);
  assign in_ready   = ~in_vld_r | advance;
  assign in_fire    = in_valid & in_ready;
  assign in_vld_nxt = in_fire | (in_vld_r & ~advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pix_r <= in_pixel_index;
    end
  end

  ipp_pack u_pack (
    .depth     (depth_r),
    .row_width (row_width_r),
    .col       (col_r),
    .partial   (partial_r),
    .pix       (pix_r),
    .res       (res)
  );

  // Update the column and partial byte once per packed pixel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      partial_r <= '0;
    end else if (advance) begin
      col_r     <= res.col_nxt;
      partial_r <= res.partial_nxt;
    end
  end

  ipp_out_reg u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (advance & res.emit),
    .load_byte       (res.out_byte),
    .load_row_end    (res.row_end),
    .out_ready       (out_ready),
    .free            (out_free),
    .out_valid       (out_valid),
    .out_packed_byte (out_packed_byte),
    .out_row_end     (out_row_end)
  );

endmodule

// ===== rtl/ipp_checker.sv =====
// Port-level checks for the indexed pixel packer, bound to its top level.
module ipp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ipp_pkg::BYTE_W-1:0] out_packed_byte,
  input logic                       out_row_end
);
  import ipp_pkg::*;

  // Reset empties both registers.
  a_rst_out_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_rst_in_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low right after reset");

  // Input back-pressure comes only from a stalled result word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while result side free");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_packed_byte) && $stable(out_row_end)))
    else $error("stalled result word changed");

endmodule

bind indexed_pixel_packer_core ipp_checker u_ipp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_packed_byte (out_packed_byte),
  .out_row_end     (out_row_end)
);
